// File: hw/rtl/ptmr_pkg.sv
// Shared constants, types and codes for the paged monochrome rectangle drawer.
`timescale 1ns / 1ps

package ptmr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int ROWS_PER_PAGE = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
    localparam int STORE_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int X_W           = $clog2(SCREEN_WIDTH);
    localparam int Y_W           = $clog2(SCREEN_HEIGHT);
    localparam int LEN_MAX       = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int CNT_W         = $clog2(LEN_MAX + 1);
    localparam int COORD_W       = 16;
    localparam int IDX_W         = 10;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_PIXEL = 3'd0,
        OP_HLINE = 3'd1,
        OP_VLINE = 3'd2,
        OP_RECT  = 3'd3,
        OP_CLEAR = 3'd4,
        OP_READ  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        PART_TOP,
        PART_BOTTOM,
        PART_LEFT,
        PART_RIGHT
    } rect_part_t;

    typedef enum logic [1:0] {
        JOB_LINE,
        JOB_CLEAR,
        JOB_READ
    } job_kind_t;

    // One unit of work for the back end: a clipped run of pixels, a clear
    // sweep, or a byte read.
    typedef struct packed {
        job_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic [CNT_W-1:0]  count;
        logic              vertical;
        logic              pixel_on;
        logic              read_ok;
    } job_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RMW_READ,
        BK_RMW_WRITE,
        BK_RD_WAIT
    } back_state_t;

endpackage

// File: hw/rtl/ptmr_front.sv
// Command front end: accept requests, clip them and split them into store jobs.
`timescale 1ns / 1ps

module ptmr_front
    import ptmr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [2:0]         s_opcode,
    input  logic [COORD_W-1:0] s_pos_x,
    input  logic [COORD_W-1:0] s_pos_y,
    input  logic [COORD_W-1:0] s_extent,
    input  logic [COORD_W-1:0] s_rect_height,
    input  logic               s_pixel_on,
    input  logic [IDX_W-1:0]   s_read_index,
    input  logic               init_done,
    input  logic               job_full,
    output logic               job_push,
    output job_t               job_data
);

    function automatic job_t make_line(
        input logic [COORD_W-1:0] sx,
        input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] len,
        input logic               vert,
        input logic               on
    );
        job_t             j;
        logic             on_screen;
        logic [X_W-1:0]   xx;
        logic [Y_W-1:0]   yy;
        logic [CNT_W-1:0] room;
        logic [CNT_W-1:0] cnt;
        on_screen = (sx < COORD_W'(SCREEN_WIDTH)) && (sy < COORD_W'(SCREEN_HEIGHT));
        xx = sx[X_W-1:0];
        yy = sy[Y_W-1:0];
        room = vert ? (CNT_W'(SCREEN_HEIGHT) - CNT_W'(yy))
                    : (CNT_W'(SCREEN_WIDTH) - CNT_W'(xx));
        if (len < COORD_W'(room)) begin
            cnt = len[CNT_W-1:0];
        end else begin
            cnt = room;
        end
        j          = '0;
        j.kind     = JOB_LINE;
        j.addr     = ADDR_W'(yy >> 3) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(xx);
        j.bit_sel  = yy[2:0];
        j.count    = on_screen ? cnt : '0;
        j.vertical = vert;
        j.pixel_on = on;
        return j;
    endfunction

    logic               cmd_valid_reg, cmd_valid_next;
    opcode_t            cmd_op_reg, cmd_op_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COORD_W-1:0] ext_reg, ext_next;
    logic [COORD_W-1:0] h_reg, h_next;
    logic [COORD_W-1:0] bottom_reg, bottom_next;
    logic [COORD_W-1:0] right_reg, right_next;
    logic               on_reg, on_next;
    logic [IDX_W-1:0]   ridx_reg, ridx_next;
    rect_part_t         part_reg, part_next;

    logic               accept;
    logic               has_job;
    logic               step_done;
    logic               last_part;
    job_t               job;

    assign s_tready = !cmd_valid_reg && init_done;
    assign accept   = s_tvalid && s_tready;

    // Job for the current command, or the current edge of a rectangle
    always_comb begin
        job     = '0;
        has_job = 1'b0;
        case (cmd_op_reg)
            OP_PIXEL: begin
                job     = make_line(x_reg, y_reg, COORD_W'(1), 1'b0, on_reg);
                has_job = (job.count != '0);
            end
            OP_HLINE: begin
                job     = make_line(x_reg, y_reg, ext_reg, 1'b0, on_reg);
                has_job = (job.count != '0);
            end
            OP_VLINE: begin
                job     = make_line(x_reg, y_reg, ext_reg, 1'b1, on_reg);
                has_job = (job.count != '0);
            end
            OP_RECT: begin
                case (part_reg)
                    PART_TOP:    job = make_line(x_reg, y_reg, ext_reg, 1'b0, on_reg);
                    PART_BOTTOM: job = make_line(x_reg, bottom_reg, ext_reg, 1'b0, on_reg);
                    PART_LEFT:   job = make_line(x_reg, y_reg, h_reg, 1'b1, on_reg);
                    PART_RIGHT:  job = make_line(right_reg, y_reg, h_reg, 1'b1, on_reg);
                    default:     job = '0;
                endcase
                has_job = (job.count != '0);
            end
            OP_CLEAR: begin
                job.kind = JOB_CLEAR;
                has_job  = 1'b1;
            end
            OP_READ: begin
                job.kind    = JOB_READ;
                job.addr    = ADDR_W'(ridx_reg);
                job.read_ok = (32'(ridx_reg) < 32'(STORE_BYTES));
                has_job     = 1'b1;
            end
            default: begin
                job     = '0;
                has_job = 1'b0;
            end
        endcase
    end

    assign job_data  = job;
    assign job_push  = cmd_valid_reg && has_job && !job_full;
    assign step_done = cmd_valid_reg && (!has_job || !job_full);
    assign last_part = (cmd_op_reg != OP_RECT) || (part_reg == PART_RIGHT);

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        cmd_op_next    = cmd_op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ext_next       = ext_reg;
        h_next         = h_reg;
        bottom_next    = bottom_reg;
        right_next     = right_reg;
        on_next        = on_reg;
        ridx_next      = ridx_reg;
        part_next      = part_reg;
        if (accept) begin
            cmd_valid_next = 1'b1;
            cmd_op_next    = opcode_t'(s_opcode);
            x_next         = s_pos_x;
            y_next         = s_pos_y;
            ext_next       = s_extent;
            h_next         = s_rect_height;
            // edges wrap at 16 bits
            bottom_next    = s_pos_y + s_rect_height - COORD_W'(1);
            right_next     = s_pos_x + s_extent - COORD_W'(1);
            on_next        = s_pixel_on;
            ridx_next      = s_read_index;
            part_next      = PART_TOP;
        end else if (step_done) begin
            if (last_part) begin
                cmd_valid_next = 1'b0;
                part_next      = PART_TOP;
            end else begin
                part_next = rect_part_t'(part_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            part_reg      <= PART_TOP;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            part_reg      <= part_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_op_reg <= cmd_op_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ext_reg    <= ext_next;
        h_reg      <= h_next;
        bottom_reg <= bottom_next;
        right_reg  <= right_next;
        on_reg     <= on_next;
        ridx_reg   <= ridx_next;
    end

endmodule

// File: hw/rtl/ptmr_queue.sv
// Short job queue between the command front end and the store back end.
`timescale 1ns / 1ps

module ptmr_queue
    import ptmr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full  = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/ptmr_back.sv
// Store back end: frame store, pixel read-modify-write, clear sweep and byte read.
`timescale 1ns / 1ps

module ptmr_back
    import ptmr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_empty,
    input  job_t       job_head,
    output logic       job_pop,
    output logic       init_done,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_read_data
);

    logic [7:0]        store_mem [STORE_BYTES];
    logic [7:0]        rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [2:0]        bit_reg, bit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              vert_reg, vert_next;
    logic              on_reg, on_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              init_done_reg, init_done_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mask;
    logic              clr_last;

    assign mask        = 8'd1 << bit_reg;
    assign clr_last    = (clr_addr_reg == ADDR_W'(STORE_BYTES - 1));
    assign m_tvalid    = out_valid_reg;
    assign m_read_data = out_data_reg;
    assign init_done   = init_done_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_last) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!job_empty) begin
                    case (job_head.kind)
                        JOB_LINE:  state_next = BK_RMW_READ;
                        JOB_CLEAR: state_next = BK_CLEAR;
                        JOB_READ:  state_next = out_valid_reg ? BK_IDLE : BK_RD_WAIT;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_RMW_READ:  state_next = BK_RMW_WRITE;
            BK_RMW_WRITE: state_next = (count_reg == CNT_W'(1)) ? BK_IDLE : BK_RMW_READ;
            BK_RD_WAIT:   state_next = BK_IDLE;
            default:      state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        job_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = rd_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;
        clr_addr_next  = clr_addr_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        count_next     = count_reg;
        vert_next      = vert_reg;
        on_next        = on_reg;
        ok_next        = ok_reg;
        out_data_next  = out_data_reg;
        init_done_next = init_done_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            BK_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_last) begin
                    init_done_next = 1'b1;
                end
            end
            BK_IDLE: begin
                if (!job_empty) begin
                    case (job_head.kind)
                        JOB_LINE: begin
                            job_pop    = 1'b1;
                            addr_next  = job_head.addr;
                            bit_next   = job_head.bit_sel;
                            count_next = job_head.count;
                            vert_next  = job_head.vertical;
                            on_next    = job_head.pixel_on;
                        end
                        JOB_CLEAR: begin
                            job_pop       = 1'b1;
                            clr_addr_next = '0;
                        end
                        JOB_READ: begin
                            // hold the read until the result register is free
                            if (!out_valid_reg) begin
                                job_pop   = 1'b1;
                                mem_re    = 1'b1;
                                mem_raddr = job_head.addr;
                                ok_next   = job_head.read_ok;
                            end
                        end
                        default: begin
                            job_pop = 1'b0;
                        end
                    endcase
                end
            end
            BK_RMW_READ: begin
                mem_re = 1'b1;
            end
            BK_RMW_WRITE: begin
                mem_we     = 1'b1;
                mem_wdata  = on_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
                count_next = count_reg - CNT_W'(1);
                if (!vert_reg) begin
                    addr_next = addr_reg + ADDR_W'(1);
                end else if (bit_reg == 3'd7) begin
                    bit_next  = 3'd0;
                    addr_next = addr_reg + ADDR_W'(SCREEN_WIDTH);
                end else begin
                    bit_next = bit_reg + 3'd1;
                end
            end
            BK_RD_WAIT: begin
                out_valid_next = 1'b1;
                out_data_next  = ok_reg ? rd_data_reg : 8'd0;
            end
            default: begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            init_done_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            init_done_reg <= init_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        bit_reg      <= bit_next;
        count_reg    <= count_next;
        vert_reg     <= vert_next;
        on_reg       <= on_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

`ifndef ASSERT_OFF
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_RMW_WRITE |-> $past(state_reg) == BK_RMW_READ)
        else $error("pixel write without a preceding store read");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> !job_empty)
        else $error("job popped from an empty queue");

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_RD_WAIT |-> !out_valid_reg)
        else $error("read completes while a result is still pending");

    a_line_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_RMW_READ |-> count_reg != '0)
        else $error("pixel run started with zero count");
`endif

endmodule

// File: hw/rtl/page_tiled_mono_rect_drawer.sv
// Top level of the paged monochrome pixel, line and rectangle drawer.
`timescale 1ns / 1ps

// Drawing engine over a 1-bit frame store organized in pages of eight rows:
// byte page*SCREEN_WIDTH+column holds one column of a page, bit 0 the top row.
// A request on the s_ channel sets or clears a pixel, draws a horizontal or
// vertical line, draws a rectangle outline, clears the store, or reads back
// one store byte; only the read request returns a result, on the m_ channel.
// Off-screen pixels are dropped and lines stop at the right or bottom edge.
// A front stage takes one request, clips it and turns it into store jobs (a
// rectangle gives up to four side runs); a four-entry job queue decouples it
// from the back stage, which owns the store. Every pixel is a read-modify-
// write over the store's registered read port: the byte is read, then
// written back with its bit set or cleared. A clear writes zero to all
// STORE_BYTES bytes (1024 with the default 128x64 screen). After reset the
// back stage sweeps zeros through the whole store (STORE_BYTES bytes, 1024
// by default) and s_tready stays low until it is done. A finished read
// result waits in an output register while further requests keep flowing
// into the queue; a second read holds until the first result has been
// taken.

module page_tiled_mono_rect_drawer
    import ptmr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] extent, [63:48] rect_height,
    // [64] pixel_on, [74:65] read_index, [79:75] zero
    input  logic [79:0] s_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data
    output logic [7:0]  m_tdata
);

    job_t push_job;
    job_t head_job;
    logic job_push;
    logic job_pop;
    logic job_full;
    logic job_empty;
    logic init_done;

    // Unpack the request fields and hand them to the front stage
    ptmr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_opcode      (s_tuser),
        .s_pos_x       (s_tdata[15:0]),
        .s_pos_y       (s_tdata[31:16]),
        .s_extent      (s_tdata[47:32]),
        .s_rect_height (s_tdata[63:48]),
        .s_pixel_on    (s_tdata[64]),
        .s_read_index  (s_tdata[74:65]),
        .init_done     (init_done),
        .job_full      (job_full),
        .job_push      (job_push),
        .job_data      (push_job)
    );

    // Hold clipped jobs in request order
    ptmr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_job),
        .pop       (job_pop),
        .head      (head_job),
        .full      (job_full),
        .empty     (job_empty)
    );

    // Carry the jobs out against the frame store
    ptmr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_empty   (job_empty),
        .job_head    (head_job),
        .job_pop     (job_pop),
        .init_done   (init_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_read_data (m_tdata)
    );

endmodule
